// ===== hdl/mwfp_pkg.sv =====
// Shared types and constants for the wired M-Bus frame parser.
// Used by mwfp_parser, mwfp_out_reg and mbus_wired_frame_parser_top; no dependencies.
package mwfp_pkg;

   localparam logic [7:0] MWFP_ACK_BYTE    = 8'hE5;
   localparam logic [7:0] MWFP_SHORT_START = 8'h10;
   localparam logic [7:0] MWFP_LONG_START  = 8'h68;
   localparam logic [7:0] MWFP_STOP_BYTE   = 8'h16;
   localparam logic [7:0] MWFP_MIN_LEN     = 8'h03;

   typedef enum logic [3:0] {
      PH_HUNT    = 4'd0,
      PH_SHORT_C = 4'd1,
      PH_SHORT_A = 4'd2,
      PH_LEN1    = 4'd3,
      PH_LEN2    = 4'd4,
      PH_START2  = 4'd5,
      PH_BODY    = 4'd6,
      PH_CHECK   = 4'd7,
      PH_STOP    = 4'd8
   } mwfp_phase_type;

   typedef enum logic [2:0] {
      K_ACK   = 3'd0,
      K_SHORT = 3'd1,
      K_CTRL  = 3'd2,
      K_LONG  = 3'd3,
      K_DATA  = 3'd4,
      K_BADST = 3'd5,
      K_FRERR = 3'd6
   } mwfp_kind_type;

   typedef struct packed {
      mwfp_kind_type kind;
      logic          sum_ok;
      logic          stop_ok;
      logic [7:0]    control_field;
      logic [7:0]    address_field;
      logic [7:0]    ci_field;
      logic [7:0]    received_sum;
      logic [7:0]    payload_byte;
      logic [7:0]    payload_count;
   } mwfp_result_type;

endpackage

// ===== hdl/mbus_wired_frame_parser_top.sv =====
// Wired M-Bus link-layer frame parser, top level.
// Instantiates mwfp_parser and mwfp_out_reg; depends on mwfp_pkg.
//
// Usage:
//   req channel: one received byte per request (req_rx_byte), valid/ready.
//   rsp channel: zero or one result per byte: ack, short/control/long frame
//   end with C, A, CI, checksum and flags, data byte, bad start byte or
//   framing error, valid/ready.
//   A byte is captured into an input register, parsed by the frame state
//   logic and its result, if any, written into the result register, which
//   drives rsp_valid.
//   Throughput is one byte per cycle while the result register is empty
//   or being read; the parse step sits between the two registers.
//   When rsp_ready is low and a result is held, the parse step stops and
//   req_ready falls once the input register is also occupied; nothing is
//   dropped. Bytes that give no result leave the result register untouched.
//   Reset (synchronous, active high) empties both registers and returns the
//   parser to hunting for a start byte.
module mbus_wired_frame_parser_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_kind,
   output logic       rsp_sum_ok,
   output logic       rsp_stop_ok,
   output logic [7:0] rsp_control_field,
   output logic [7:0] rsp_address_field,
   output logic [7:0] rsp_ci_field,
   output logic [7:0] rsp_received_sum,
   output logic [7:0] rsp_payload_byte,
   output logic [7:0] rsp_payload_count
);
   import mwfp_pkg::*;

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff;
   logic            step_en;
   logic            res_emit;
   mwfp_result_type res;
   mwfp_result_type out_data;

   assign step_en   = in_valid_ff && (!rsp_valid || rsp_ready);
   assign req_ready = !in_valid_ff || step_en;

   always_comb begin
      priority if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (step_en) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   mwfp_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .step_en  (step_en),
      .rx_byte  (in_byte_ff),
      .res_emit (res_emit),
      .res      (res)
   );

   mwfp_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load_en    (step_en),
      .load_valid (res_emit),
      .load_data  (res),
      .out_ready  (rsp_ready),
      .out_valid  (rsp_valid),
      .out_data   (out_data)
   );

   assign rsp_kind          = out_data.kind;
   assign rsp_sum_ok        = out_data.sum_ok;
   assign rsp_stop_ok       = out_data.stop_ok;
   assign rsp_control_field = out_data.control_field;
   assign rsp_address_field = out_data.address_field;
   assign rsp_ci_field      = out_data.ci_field;
   assign rsp_received_sum  = out_data.received_sum;
   assign rsp_payload_byte  = out_data.payload_byte;
   assign rsp_payload_count = out_data.payload_count;

endmodule

// ===== hdl/mwfp_parser.sv =====
// Frame parser state and per-byte result logic for the wired M-Bus parser.
// Depends on mwfp_pkg.
module mwfp_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_en,
   input  logic [7:0]               rx_byte,
   output logic                     res_emit,
   output mwfp_pkg::mwfp_result_type res
);
   import mwfp_pkg::*;

   mwfp_phase_type phase_ff, phase_in;
   logic [7:0] position_ff, position_in;
   logic [7:0] first_length_ff, first_length_in;
   logic [7:0] frame_length_ff, frame_length_in;
   logic [7:0] running_sum_ff, running_sum_in;
   logic [7:0] held_control_ff, held_control_in;
   logic [7:0] held_address_ff, held_address_in;
   logic [7:0] held_ci_ff, held_ci_in;
   logic [7:0] held_sum_ff, held_sum_in;
   logic       sum_matched_ff, sum_matched_in;
   logic [7:0] body_sum;

   assign body_sum = running_sum_ff + rx_byte;

   always_comb begin
      phase_in        = phase_ff;
      position_in     = position_ff;
      first_length_in = first_length_ff;
      frame_length_in = frame_length_ff;
      running_sum_in  = running_sum_ff;
      held_control_in = held_control_ff;
      held_address_in = held_address_ff;
      held_ci_in      = held_ci_ff;
      held_sum_in     = held_sum_ff;
      sum_matched_in  = sum_matched_ff;
      unique case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == MWFP_SHORT_START) begin
               running_sum_in  = '0;
               frame_length_in = '0;
               held_ci_in      = '0;
               phase_in        = PH_SHORT_C;
            end else if (rx_byte == MWFP_LONG_START) begin
               phase_in = PH_LEN1;
            end
         end
         PH_SHORT_C: begin
            held_control_in = rx_byte;
            running_sum_in  = body_sum;
            phase_in        = PH_SHORT_A;
         end
         PH_SHORT_A: begin
            held_address_in = rx_byte;
            running_sum_in  = body_sum;
            phase_in        = PH_CHECK;
         end
         PH_LEN1: begin
            first_length_in = rx_byte;
            phase_in        = PH_LEN2;
         end
         PH_LEN2: begin
            if (rx_byte != first_length_ff || rx_byte < MWFP_MIN_LEN) begin
               phase_in = PH_HUNT;
            end else begin
               frame_length_in = rx_byte;
               phase_in        = PH_START2;
            end
         end
         PH_START2: begin
            if (rx_byte != MWFP_LONG_START) begin
               phase_in = PH_HUNT;
            end else begin
               running_sum_in = '0;
               position_in    = '0;
               phase_in       = PH_BODY;
            end
         end
         PH_BODY: begin
            running_sum_in = body_sum;
            if (position_ff == 8'd0) begin
               held_control_in = rx_byte;
            end else if (position_ff == 8'd1) begin
               held_address_in = rx_byte;
            end else if (position_ff == 8'd2) begin
               held_ci_in = rx_byte;
            end
            position_in = position_ff + 8'd1;
            if (position_in == frame_length_ff) begin
               phase_in = PH_CHECK;
            end
         end
         PH_CHECK: begin
            held_sum_in    = rx_byte;
            sum_matched_in = (rx_byte == running_sum_ff);
            phase_in       = PH_STOP;
         end
         PH_STOP: begin
            phase_in = PH_HUNT;
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   always_comb begin
      res_emit = 1'b0;
      res      = '0;
      unique case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == MWFP_ACK_BYTE) begin
               res_emit = 1'b1;
               res.kind = K_ACK;
            end else if (rx_byte != MWFP_SHORT_START && rx_byte != MWFP_LONG_START) begin
               res_emit         = 1'b1;
               res.kind         = K_BADST;
               res.payload_byte = rx_byte;
            end
         end
         PH_LEN2: begin
            if (rx_byte != first_length_ff || rx_byte < MWFP_MIN_LEN) begin
               res_emit = 1'b1;
               res.kind = K_FRERR;
            end
         end
         PH_START2: begin
            if (rx_byte != MWFP_LONG_START) begin
               res_emit = 1'b1;
               res.kind = K_FRERR;
            end
         end
         PH_BODY: begin
            if (position_ff > 8'd2) begin
               res_emit          = 1'b1;
               res.kind          = K_DATA;
               res.payload_byte  = rx_byte;
               res.payload_count = position_ff - 8'd2;
            end
         end
         PH_STOP: begin
            res_emit = 1'b1;
            priority if (frame_length_ff == 8'd0) begin
               res.kind = K_SHORT;
            end else if (frame_length_ff == MWFP_MIN_LEN) begin
               res.kind = K_CTRL;
            end else begin
               res.kind = K_LONG;
            end
            res.sum_ok        = sum_matched_ff;
            res.stop_ok       = (rx_byte == MWFP_STOP_BYTE);
            res.control_field = held_control_ff;
            res.address_field = held_address_ff;
            res.ci_field      = (frame_length_ff == 8'd0) ? 8'd0 : held_ci_ff;
            res.received_sum  = held_sum_ff;
            res.payload_count = (frame_length_ff > MWFP_MIN_LEN) ?
                                (frame_length_ff - MWFP_MIN_LEN) : 8'd0;
         end
         default: begin
            res_emit = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
      end else if (step_en) begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         position_ff     <= position_in;
         first_length_ff <= first_length_in;
         frame_length_ff <= frame_length_in;
         running_sum_ff  <= running_sum_in;
         held_control_ff <= held_control_in;
         held_address_ff <= held_address_in;
         held_ci_ff      <= held_ci_in;
         held_sum_ff     <= held_sum_in;
         sum_matched_ff  <= sum_matched_in;
      end
   end

endmodule

// ===== hdl/mwfp_out_reg.sv =====
// Result register with valid/ready handshake for the wired M-Bus parser.
// Depends on mwfp_pkg.
module mwfp_out_reg (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load_en,
   input  logic                      load_valid,
   input  mwfp_pkg::mwfp_result_type load_data,
   input  logic                      out_ready,
   output logic                      out_valid,
   output mwfp_pkg::mwfp_result_type out_data
);
   import mwfp_pkg::*;

   logic            valid_ff, valid_in;
   mwfp_result_type data_ff;

   always_comb begin
      priority if (load_en) begin
         valid_in = load_valid;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en && load_valid) begin
         data_ff <= load_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
